[design/blpg_pkg.sv]
package blpg_pkg;

   // Default coordinate width and fixed field widths
   localparam int COORD_BITS_DEF = 12;
   localparam int SCREEN_BITS    = 12;
   localparam int COLOR_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Screen size after reset
   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd128;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd160;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // Opcodes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_VALID = 2'd0,
      STATUS_OOB   = 2'd1,
      STATUS_IDLE  = 2'd2
   } status_type;

   // Status and end-of-line marker of one pixel
   typedef struct packed {
      status_type status;
      logic       last;
   } pix_flags_type;

   // Panel wants the high byte first
   function automatic logic [COLOR_BITS-1:0] swap_bytes(input logic [COLOR_BITS-1:0] c);
      return {c[7:0], c[15:8]};
   endfunction

endpackage

[design/blpg_req_if.sv]
interface blpg_req_if import blpg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0] pixel_color;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, pixel_color,
                   input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, pixel_color,
                   output ready);
endinterface

[design/blpg_rsp_if.sv]
interface blpg_rsp_if import blpg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [COLOR_BITS-1:0] out_color;
   logic [1:0]            status;
   logic                  last;

   modport source (output valid, out_x, out_y, out_color, status, last, input ready);
   modport sink   (input valid, out_x, out_y, out_color, status, last, output ready);
endinterface

[design/blpg_csr_if.sv]
interface blpg_csr_if import blpg_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [SCREEN_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/blpg_walker.sv]
module blpg_walker import blpg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   opcode,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [COORD_BITS-1:0]  end_x,
   input  logic [COORD_BITS-1:0]  end_y,
   input  logic [COLOR_BITS-1:0]  pixel_color,
   input  logic [SCREEN_BITS-1:0] screen_width,
   input  logic [SCREEN_BITS-1:0] screen_height,
   output logic [COORD_BITS-1:0]  pix_x,
   output logic [COORD_BITS-1:0]  pix_y,
   output logic [COLOR_BITS-1:0]  pix_color,
   output pix_flags_type          pix_flags
);

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int E2_BITS  = COORD_BITS + 3;
   localparam int CMP_BITS = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

   // Line state
   logic [COORD_BITS-1:0]      cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic [COORD_BITS-1:0]      tgt_x_ff, tgt_y_ff;
   logic [COORD_BITS-1:0]      abs_dx_ff, abs_dy_ff, abs_dx_in, abs_dy_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic                       x_neg_ff, y_neg_ff;
   logic [COLOR_BITS-1:0]      color_ff;
   logic                       active_ff, active_in;

   logic                       is_load, is_idle;
   logic [COORD_BITS:0]        diff_x, diff_y, ndiff_x, ndiff_y;
   logic signed [ERR_BITS-1:0] err_load, err_adv;
   logic signed [E2_BITS-1:0]  e2, neg_dy, pos_dx;
   logic                       step_x, step_y;
   logic [COORD_BITS-1:0]      adv_x, adv_y, tgt_x, tgt_y;
   logic [COLOR_BITS-1:0]      color;
   logic                       in_bounds, at_end;

   assign is_load = (opcode == OP_LOAD);
   assign is_idle = !is_load && !active_ff;

   // Load: absolute deltas and initial error term
   assign diff_x  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
   assign diff_y  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
   assign ndiff_x = -diff_x;
   assign ndiff_y = -diff_y;
   assign abs_dx_in = diff_x[COORD_BITS] ? ndiff_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
   assign abs_dy_in = diff_y[COORD_BITS] ? ndiff_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
   assign err_load  = $signed({2'b00, abs_dx_in}) - $signed({2'b00, abs_dy_in});

   // Advance: one Bresenham step
   assign e2     = $signed({err_ff, 1'b0});
   assign neg_dy = -$signed({3'b000, abs_dy_ff});
   assign pos_dx = $signed({3'b000, abs_dx_ff});
   assign step_x = (e2 > neg_dy);
   assign step_y = (e2 < pos_dx);

   always_comb begin
      err_adv = err_ff;
      adv_x   = cur_x_ff;
      adv_y   = cur_y_ff;
      if (step_x) begin
         err_adv = err_adv - $signed({2'b00, abs_dy_ff});
         adv_x   = x_neg_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      end
      if (step_y) begin
         err_adv = err_adv + $signed({2'b00, abs_dx_ff});
         adv_y   = y_neg_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
      end
   end

   // Pixel under test: first pixel on load, stepped pixel otherwise
   assign cur_x_in = is_load ? start_x : adv_x;
   assign cur_y_in = is_load ? start_y : adv_y;
   assign err_in   = is_load ? err_load : err_adv;
   assign tgt_x    = is_load ? end_x : tgt_x_ff;
   assign tgt_y    = is_load ? end_y : tgt_y_ff;
   assign color    = is_load ? pixel_color : color_ff;

   assign in_bounds = !cur_x_in[COORD_BITS-1] && !cur_y_in[COORD_BITS-1] &&
                      (CMP_BITS'(cur_x_in) < CMP_BITS'(screen_width)) &&
                      (CMP_BITS'(cur_y_in) < CMP_BITS'(screen_height));
   assign at_end    = (cur_x_in == tgt_x) && (cur_y_in == tgt_y);
   assign active_in = in_bounds && !at_end;

   // Result of this item
   always_comb begin
      if (is_idle) begin
         pix_x            = '0;
         pix_y            = '0;
         pix_color        = '0;
         pix_flags.status = STATUS_IDLE;
         pix_flags.last   = 1'b0;
      end else begin
         pix_x            = cur_x_in;
         pix_y            = cur_y_in;
         pix_color        = swap_bytes(color);
         pix_flags.status = in_bounds ? STATUS_VALID : STATUS_OOB;
         pix_flags.last   = !active_in;
      end
   end

   // Line state update on each transfer that is not an idle advance
   always_ff @(posedge clock) begin
      if (take && !is_idle) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         err_ff   <= err_in;
      end
      if (take && is_load) begin
         tgt_x_ff  <= end_x;
         tgt_y_ff  <= end_y;
         abs_dx_ff <= abs_dx_in;
         abs_dy_ff <= abs_dy_in;
         x_neg_ff  <= !($signed(start_x) < $signed(end_x));
         y_neg_ff  <= !($signed(start_y) < $signed(end_y));
         color_ff  <= pixel_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (take && !is_idle) begin
         active_ff <= active_in;
      end
   end

endmodule

[design/bresenham_line_pixel_generator.sv]
// Integer line rasterizer for a small display. A load request (opcode 0)
// takes two signed endpoints and an RGB565 color and returns the first pixel;
// each advance request (opcode 1) returns the next pixel of the line, in any
// octant. Every response carries the pixel position, the color with its bytes
// swapped for the panel, a status (valid, out of bounds, idle) and a last flag
// on the final pixel. A pixel outside the screen size held in the two
// configuration registers (width at index 0, height at index 1) ends the line.
// The block takes one request per clock while its output register is free or
// being drained, and presents its response in the cycle after the transfer:
// the walker's error update, step and bounds compare are combinational, and one
// output register keeps accepting while the sink takes the previous response.
module bresenham_line_pixel_generator import blpg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   blpg_req_if.sink   req_chan,
   blpg_rsp_if.source rsp_chan,
   blpg_csr_if.sink   csr_chan
);

   logic [SCREEN_BITS-1:0] screen_width_ff, screen_height_ff;
   logic                   req_take;
   logic [COORD_BITS-1:0]  pix_x, pix_y;
   logic [COLOR_BITS-1:0]  pix_color;
   pix_flags_type          pix_flags;

   logic                   rsp_valid_ff;
   logic [COORD_BITS-1:0]  out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0]  out_color_ff;
   pix_flags_type          flags_ff;

   // Configuration registers, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_chan.data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Accept whenever the output register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   blpg_walker #(.COORD_BITS(COORD_BITS)) u_walker (
      .clock        (clock),
      .reset        (reset),
      .take         (req_take),
      .opcode       (req_chan.opcode),
      .start_x      (req_chan.start_x),
      .start_y      (req_chan.start_y),
      .end_x        (req_chan.end_x),
      .end_y        (req_chan.end_y),
      .pixel_color  (req_chan.pixel_color),
      .screen_width (screen_width_ff),
      .screen_height(screen_height_ff),
      .pix_x        (pix_x),
      .pix_y        (pix_y),
      .pix_color    (pix_color),
      .pix_flags    (pix_flags)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         out_x_ff     <= pix_x;
         out_y_ff     <= pix_y;
         out_color_ff <= pix_color;
         flags_ff     <= pix_flags;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_x     = out_x_ff;
   assign rsp_chan.out_y     = out_y_ff;
   assign rsp_chan.out_color = out_color_ff;
   assign rsp_chan.status    = flags_ff.status;
   assign rsp_chan.last      = flags_ff.last;

endmodule

[design/blpg_checker.sv]
module blpg_checker import blpg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] out_x,
   input logic [COORD_BITS-1:0] out_y,
   input logic [COLOR_BITS-1:0] out_color,
   input logic [1:0]            status,
   input logic                  last
);

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y) &&
                                  $stable(out_color) && $stable(status) && $stable(last))
      else $error("stalled response changed");

   // An empty output stage never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // Out-of-bounds pixel always ends the line
   a_oob_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_OOB |-> last)
      else $error("out-of-bounds pixel without last");

   // Idle responses carry no pixel
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_IDLE |->
         !last && out_x == '0 && out_y == '0 && out_color == '0)
      else $error("idle response carries data");

endmodule

bind bresenham_line_pixel_generator blpg_checker #(.COORD_BITS(COORD_BITS)) u_blpg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .out_x    (rsp_chan.out_x),
   .out_y    (rsp_chan.out_y),
   .out_color(rsp_chan.out_color),
   .status   (rsp_chan.status),
   .last     (rsp_chan.last)
);

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import blpg_pkg::*;

   localparam int CB          = COORD_BITS_DEF;
   localparam int CYCLE_LIMIT = 500000;

   // Indexes outside the register map, written to show they are ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_B = 2'd3;

   typedef struct packed {
      logic                  opcode;
      logic [CB-1:0]         start_x;
      logic [CB-1:0]         start_y;
      logic [CB-1:0]         end_x;
      logic [CB-1:0]         end_y;
      logic [COLOR_BITS-1:0] pixel_color;
   } line_cmd_type;

   typedef struct packed {
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      status_type            status;
      logic                  last;
   } pixel_type;

   logic clock;
   logic reset;

   blpg_req_if #(.COORD_BITS(CB)) req_bus ();
   blpg_rsp_if #(.COORD_BITS(CB)) rsp_bus ();
   blpg_csr_if                    csr_bus ();

   bresenham_line_pixel_generator #(.COORD_BITS(CB)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Stimulus and expectation stores
   line_cmd_type line_cmds[$];
   pixel_type    pending_pixels[$];
   line_cmd_type req_cmd;
   pixel_type    expected_pix;

   int cmds_queued    = 0;
   int cmds_accepted  = 0;
   int pixels_checked = 0;
   int mismatches     = 0;
   int lines_loaded   = 0;
   int oob_seen       = 0;
   int idle_seen      = 0;
   int csr_writes     = 0;
   int cycles         = 0;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int req_gap       = 0;
   int rsp_stall     = 0;

   // Line walker state, mirrors the block
   int         scr_w = 128;
   int         scr_h = 160;
   int         pen_x, pen_y, goal_x, goal_y;
   int         run_dx, run_dy, err_term;
   bit         back_x, back_y;
   logic [15:0] ink;
   bit         drawing = 1'b0;

   // Clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Report the pen position and close the line when it leaves the screen or arrives
   function automatic pixel_type plot_pen();
      pixel_type p;
      bit        on_screen;
      bit        at_goal;
      on_screen = pen_x >= 0 && pen_y >= 0 && pen_x < scr_w && pen_y < scr_h;
      at_goal   = pen_x == goal_x && pen_y == goal_y;
      p.x       = CB'(pen_x);
      p.y       = CB'(pen_y);
      p.color   = {ink[7:0], ink[15:8]};
      p.status  = on_screen ? STATUS_VALID : STATUS_OOB;
      p.last    = !on_screen || at_goal;
      drawing   = on_screen && !at_goal;
      if (!on_screen)
         oob_seen++;
      return p;
   endfunction

   // Next pixel for one command, updating the walker
   function automatic pixel_type rasterize(input line_cmd_type c);
      pixel_type p;
      int        e2;
      if (c.opcode == OP_LOAD) begin
         pen_x    = int'($signed(c.start_x));
         pen_y    = int'($signed(c.start_y));
         goal_x   = int'($signed(c.end_x));
         goal_y   = int'($signed(c.end_y));
         run_dx   = goal_x >= pen_x ? goal_x - pen_x : pen_x - goal_x;
         run_dy   = goal_y >= pen_y ? goal_y - pen_y : pen_y - goal_y;
         err_term = run_dx - run_dy;
         back_x   = !(pen_x < goal_x);
         back_y   = !(pen_y < goal_y);
         ink      = c.pixel_color;
         lines_loaded++;
         return plot_pen();
      end
      if (!drawing) begin
         p.x      = '0;
         p.y      = '0;
         p.color  = '0;
         p.status = STATUS_IDLE;
         p.last   = 1'b0;
         idle_seen++;
         return p;
      end
      e2 = 2 * err_term;
      if (e2 > -run_dy) begin
         err_term -= run_dy;
         pen_x += back_x ? -1 : 1;
      end
      if (e2 < run_dx) begin
         err_term += run_dx;
         pen_y += back_y ? -1 : 1;
      end
      return plot_pen();
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_pixels.push_back(rasterize(req_cmd));
            cmds_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (line_cmds.size() != 0 && $urandom_range(0, 99) < req_idle_pct) begin
               req_gap = $urandom_range(0, 12);
               req_bus.valid <= 1'b0;
            end else if (line_cmds.size() != 0) begin
               req_cmd = line_cmds.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.opcode      <= req_cmd.opcode;
               req_bus.start_x     <= req_cmd.start_x;
               req_bus.start_y     <= req_cmd.start_y;
               req_bus.end_x       <= req_cmd.end_x;
               req_bus.end_y       <= req_cmd.end_y;
               req_bus.pixel_color <= req_cmd.pixel_color;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] pixel with nothing expected: x=%0d y=%0d status=%0d",
                           $realtime, $signed(rsp_bus.out_x), $signed(rsp_bus.out_y),
                           rsp_bus.status);
            end else begin
               expected_pix = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_bus.out_x !== expected_pix.x || rsp_bus.out_y !== expected_pix.y ||
                   rsp_bus.out_color !== expected_pix.color ||
                   rsp_bus.status !== expected_pix.status ||
                   rsp_bus.last !== expected_pix.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("[%0t] pixel %0d mismatch (exp/act): x %0d/%0d y %0d/%0d ",
                            $realtime, pixels_checked,
                            $signed(expected_pix.x), $signed(rsp_bus.out_x),
                            $signed(expected_pix.y), $signed(rsp_bus.out_y));
                     $display("color %h/%h status %0d/%0d last %b/%b",
                              expected_pix.color, rsp_bus.out_color,
                              expected_pix.status, rsp_bus.status,
                              expected_pix.last, rsp_bus.last);
                  end
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall = $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still expected",
                  cycles, pending_pixels.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int clamp_coord(input int v);
      if (v < -2048)
         return -2048;
      if (v > 2047)
         return 2047;
      return v;
   endfunction

   function automatic int rnd_coord();
      return int'($signed(CB'($urandom)));
   endfunction

   // Mostly on screen, sometimes right on the far edge or one past it
   function automatic int pick_on_axis(input int n);
      int v;
      int top;
      top = n > 2048 ? 2048 : n;
      v = (top == 0) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, top - 1));
      if ($urandom_range(0, 7) == 0)
         v = top - int'($urandom_range(0, 1));
      return clamp_coord(v);
   endfunction

   task automatic push_cmd(input logic op, input int sx, input int sy, input int ex,
                           input int ey, input logic [15:0] color);
      line_cmd_type c;
      c.opcode      = op;
      c.start_x     = CB'(sx);
      c.start_y     = CB'(sy);
      c.end_x       = CB'(ex);
      c.end_y       = CB'(ey);
      c.pixel_color = color;
      line_cmds.push_back(c);
      cmds_queued++;
   endtask

   task automatic push_advance();
      push_cmd(OP_ADVANCE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 16'($urandom));
   endtask

   // One load followed by the advances that walk it, with some overrun or cut short
   task automatic queue_line(input bit in_view);
      int sx, sy, ex, ey;
      int span, steps, adv, sel;
      if (in_view) begin
         sx   = pick_on_axis(scr_w);
         sy   = pick_on_axis(scr_h);
         span = ($urandom_range(0, 24) == 0) ? 160 : 9;
         ex   = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
         ey   = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
         if ($urandom_range(0, 9) == 0) begin
            ex = sx;
            ey = sy;
         end
      end else begin
         sx = rnd_coord();
         sy = rnd_coord();
         ex = rnd_coord();
         ey = rnd_coord();
      end
      steps = (ex > sx ? ex - sx : sx - ex);
      if ((ey > sy ? ey - sy : sy - ey) > steps)
         steps = ey > sy ? ey - sy : sy - ey;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         adv = steps;
      else if (sel < 9)
         adv = steps + int'($urandom_range(1, 3));
      else
         adv = $urandom_range(0, steps);
      if (!in_view && adv > 24)
         adv = 24;
      push_cmd(OP_LOAD, sx, sy, ex, ey, 16'($urandom));
      repeat (adv)
         push_advance();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [11:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_SCREEN_WIDTH:  scr_w = int'(val);
         CSR_SCREEN_HEIGHT: scr_h = int'(val);
         default: ;
      endcase
   endtask

   task automatic set_screen(input int w, input int h);
      write_reg(CSR_SCREEN_WIDTH, 12'(w));
      write_reg(CSR_SCREEN_HEIGHT, 12'(h));
   endtask

   // Wait until every command is taken and every pixel seen, plus pipeline slack
   task automatic wait_drained();
      while (cmds_accepted != cmds_queued || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   task automatic run_traffic(input int count, input int idle_pct, input int stall_pct);
      int goal;
      int sel;
      goal          = cmds_queued + count;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      while (cmds_queued < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 75)
            queue_line(1'b1);
         else if (sel < 92)
            queue_line(1'b0);
         else
            push_advance();
      end
      wait_drained();
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_LOAD;
      req_bus.start_x     = '0;
      req_bus.start_y     = '0;
      req_bus.end_x       = '0;
      req_bus.end_y       = '0;
      req_bus.pixel_color = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_SCREEN_WIDTH;
      csr_bus.data        = '0;
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;

      // Directed cases on the power-up screen size
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      push_advance();                                    // advance with no line
      push_cmd(OP_LOAD, 5, 5, 5, 5, 16'hABCD);           // single-pixel line
      push_advance();
      push_cmd(OP_LOAD, 0, 0, 3, 1, 16'hFFFF);           // shallow, walk past the end
      repeat (4)
         push_advance();
      push_cmd(OP_LOAD, 10, 10, 8, 13, 16'h0000);        // steep, negative x
      repeat (3)
         push_advance();
      push_cmd(OP_LOAD, 127, 159, 120, 150, 16'h1234);   // corner pixel, then replaced
      push_advance();
      push_cmd(OP_LOAD, -1, 5, 3, 5, 16'h5A5A);          // starts off screen
      push_advance();
      push_cmd(OP_LOAD, 126, 0, 130, 0, 16'h00FF);       // runs off the right edge
      repeat (2)
         push_advance();
      push_cmd(OP_LOAD, -2048, -2048, 2047, 2047, 16'h8001);
      push_cmd(OP_LOAD, 2047, -1, -2048, 0, 16'h7FFE);
      push_cmd(OP_LOAD, 0, 159, 0, 161, 16'hC3C3);       // runs off the bottom edge
      push_advance();
      wait_drained();

      // Random phases across screen sizes
      set_screen(2048, 2048);
      run_traffic(200, 25, 25);
      set_screen(1, 1);
      run_traffic(70, 10, 40);
      set_screen(0, 37);
      write_reg(CSR_UNMAPPED_A, 12'hFFF);
      write_reg(CSR_UNMAPPED_B, 12'h800);
      run_traffic(50, 40, 10);
      set_screen($urandom_range(1, 2048), $urandom_range(1, 2048));
      run_traffic(180, 5, 50);
      set_screen(4095, 4095);
      run_traffic(80, 30, 0);
      // Final stretch at full rate
      set_screen(128, 160);
      run_traffic(250, 0, 0);

      $display("%0d commands, %0d lines loaded, %0d pixels checked, %0d register writes",
               cmds_accepted, lines_loaded, pixels_checked, csr_writes);
      $display("%0d off-screen pixels and %0d idle advances predicted, %0d mismatches",
               oob_seen, idle_seen, mismatches);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
